/* sv/ieag_pkg.sv */
// ----------------------------------------------------------------------------
// ieag_pkg
// Shared types and constants of the impulse energy auto gain block.
// ----------------------------------------------------------------------------
package ieag_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int ACC_W       = 64;
    localparam int QUO_W       = 46;
    localparam int GAIN_W      = 24;
    localparam int DIV_STEPS   = 46 + 2 * FRAC_BITS;
    localparam int SQRT_STEPS  = QUO_W / 2;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam logic [ACC_W-1:0]  ONE_ENERGY = ACC_W'(1) << (2 * FRAC_BITS);
    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << (GAIN_W - 1);

    typedef struct packed {
        logic signed [23:0] sample;
        logic               end_of_buffer;
        logic               end_of_set;
    } smp_t;

    typedef struct packed {
        logic [23:0] buffer_gain;
        logic [23:0] auto_gain;
        logic        set_done;
        logic        energy_saturated;
    } res_t;

    typedef struct packed {
        logic sq_load;
        logic acc_add;
        logic prep;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic out_load;
        logic set_end;
    } cmd_t;

endpackage

/* sv/ieag_ctrl.sv */
// ----------------------------------------------------------------------------
// ieag_ctrl
// Sequencer: sample intake, end-of-buffer flush, divide and root steps, result.
// ----------------------------------------------------------------------------
module ieag_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          smp_valid,
    input  ieag_pkg::smp_t smp,
    output logic          smp_stall,
    input  logic          le_one,
    output logic          res_valid,
    input  logic          res_stall,
    output ieag_pkg::cmd_t cmd
);
    import ieag_pkg::*;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_FLUSH,
        ST_PREP,
        ST_DIV,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_OUT
    } state_t;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sq_vld_reg, sq_vld_next;
    logic             eos_reg, eos_next;
    logic             out_vld_reg, out_vld_next;
    logic             accept;
    logic             out_free;

    assign smp_stall = (state_reg != ST_RUN);
    assign accept    = smp_valid && (state_reg == ST_RUN);
    assign out_free  = !out_vld_reg || !res_stall;
    assign res_valid = out_vld_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        sq_vld_next = sq_vld_reg;
        eos_next    = eos_reg;
        cmd         = '0;
        cmd.set_end = eos_reg;
        case (state_reg)
            ST_RUN:
            begin
                cmd.sq_load = accept;
                cmd.acc_add = sq_vld_reg;
                sq_vld_next = accept;
                if (accept && smp.end_of_buffer)
                begin
                    eos_next   = smp.end_of_set;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // last square of the buffer goes into the energy
                cmd.acc_add = sq_vld_reg;
                sq_vld_next = 1'b0;
                state_next  = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = le_one ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (cmd.out_load)
        begin
            out_vld_next = 1'b1;
        end
        else
        begin
            out_vld_next = out_vld_reg && res_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            cnt_reg     <= '0;
            sq_vld_reg  <= 1'b0;
            eos_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sq_vld_reg  <= sq_vld_next;
            eos_reg     <= eos_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

/* sv/ieag_dpath.sv */
// ----------------------------------------------------------------------------
// ieag_dpath
// Datapath: square and saturating energy sum, restoring divide, integer root,
// running minimum and result register.
// ----------------------------------------------------------------------------
module ieag_dpath (
    input  logic           clk,
    input  logic           rst_n,
    input  ieag_pkg::smp_t smp,
    input  ieag_pkg::cmd_t cmd,
    output logic           le_one,
    output ieag_pkg::res_t res
);
    import ieag_pkg::*;

    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_W-1:0]        sq_reg;
    logic [ACC_W-1:0]       energy_reg, energy_next;
    logic                   sat_reg, sat_next;
    logic [GAIN_W-1:0]      min_reg, min_next;
    logic [ACC_W:0]         sum;
    logic [ACC_W-1:0]       rem_reg;
    logic [QUO_W-1:0]       quo_reg;
    logic [QUO_W-1:0]       v_reg;
    logic [QUO_W:0]         root_reg;
    logic [QUO_W-1:0]       bit_reg;
    logic [ACC_W:0]         rem_sh;
    logic                   rem_ge;
    logic [QUO_W:0]         trial;
    logic                   v_ge;
    logic [GAIN_W-1:0]      gain;
    logic [GAIN_W-1:0]      new_min;
    res_t                   res_reg;

    // magnitude of the full 24-bit two's complement sample
    assign raw = smp.sample[SAMPLE_BITS-1:0];
    assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

    assign sum    = {1'b0, energy_reg} + (ACC_W + 1)'(sq_reg);
    assign le_one = (energy_reg <= ONE_ENERGY);

    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, energy_reg});
    assign trial  = root_reg + (QUO_W + 1)'(bit_reg);
    assign v_ge   = ({1'b0, v_reg} >= trial);

    assign gain    = root_reg[GAIN_W-1:0];
    assign new_min = (gain < min_reg) ? gain : min_reg;

    always_comb
    begin
        energy_next = energy_reg;
        sat_next    = sat_reg;
        min_next    = min_reg;
        if (cmd.acc_add)
        begin
            if (sum[ACC_W])
            begin
                energy_next = '1;
                sat_next    = 1'b1;
            end
            else
            begin
                energy_next = sum[ACC_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            energy_next = '0;
            sat_next    = 1'b0;
            min_next    = cmd.set_end ? GAIN_ONE : new_min;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            sat_reg    <= 1'b0;
            min_reg    <= GAIN_ONE;
        end
        else
        begin
            energy_reg <= energy_next;
            sat_reg    <= sat_next;
            min_reg    <= min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sq_load)
        begin
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        end

        if (cmd.prep)
        begin
            rem_reg <= ACC_W'(1);
            quo_reg <= '0;
            // low energy needs no divide, gain is one
            root_reg <= (QUO_W + 1)'(GAIN_ONE);
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_sh[ACC_W-1:0] - energy_reg;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[ACC_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end

        if (cmd.sqrt_init)
        begin
            v_reg    <= quo_reg;
            root_reg <= '0;
            bit_reg  <= QUO_W'(1) << (QUO_W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (v_ge)
            begin
                v_reg    <= v_reg - trial[QUO_W-1:0];
                root_reg <= (root_reg >> 1) + (QUO_W + 1)'(bit_reg);
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.out_load)
        begin
            res_reg.buffer_gain      <= gain;
            res_reg.auto_gain        <= new_min;
            res_reg.set_done         <= cmd.set_end;
            res_reg.energy_saturated <= sat_reg;
        end
    end

    assign res = res_reg;

endmodule

/* sv/impulse_energy_auto_gain_core.sv */
// ----------------------------------------------------------------------------
// impulse_energy_auto_gain_core
// Per-buffer energy normalisation gain with running minimum over a set.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a buffer streams in; each square is
// registered and added into a saturating 64-bit energy sum. The request that
// carries end_of_buffer closes the buffer: the block then stalls its input
// through flush, set-up, the restoring divide (one quotient bit per cycle),
// root set-up and the integer square root (one root bit per cycle) until the
// result register loads; a buffer whose energy is at most 1.0 skips the divide
// and root. The result register lets the next buffer start while the previous
// result waits to be taken, although a further result cannot load until that
// one has left.
module impulse_energy_auto_gain_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           smp_valid,
    output logic           smp_stall,
    input  ieag_pkg::smp_t smp,
    output logic           res_valid,
    input  logic           res_stall,
    output ieag_pkg::res_t res
);
    import ieag_pkg::*;

    cmd_t cmd;
    logic le_one;

    ieag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp       (smp),
        .smp_stall (smp_stall),
        .le_one    (le_one),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd)
    );

    ieag_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .smp    (smp),
        .cmd    (cmd),
        .le_one (le_one),
        .res    (res)
    );

endmodule

/* tb/impulse_energy_auto_gain_core_tb.sv */
// ----------------------------------------------------------------------------
// impulse_energy_auto_gain_core_tb
// Self-checking bench for the per-buffer energy normalisation gain block.
// Streams buffers of Q1.23 samples grouped into sets. A tracker class rebuilds
// the saturating energy sum, the inverse square root gain and the running
// minimum of each set, and checks every result field against its own figures.
// Both handshakes are throttled at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module impulse_energy_auto_gain_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ieag_pkg::*;

    localparam logic signed [23:0] SAMPLE_MIN = 24'h800000;
    localparam logic signed [23:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam int RANDOM_SAMPLES = 1950;
    localparam int DRAIN_CYCLES   = 130;

    typedef enum int {FULL_RANGE, EXTREMES, QUIET_LEVEL, LOUD} flavour_t;

    class gain_tracker;
        logic [63:0] energy;
        bit          energy_clipped;
        logic [23:0] lowest_gain;
        res_t        pending_gains[$];
        int          errors;

        function new();
            energy         = '0;
            energy_clipped = 1'b0;
            lowest_gain    = GAIN_ONE;
            errors         = 0;
        endfunction

        // floor(2^23 / sqrt(S / 2^46)), clamped to 1.0
        static function logic [23:0] inv_sqrt_gain(logic [63:0] s);
            logic [127:0] quo;
            logic [63:0]  root;
            logic [63:0]  trial;
            if (s <= ONE_ENERGY)
                return GAIN_ONE;
            quo  = (128'd1 << 92) / {64'd0, s};
            root = '0;
            for (int b = 23; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= quo[63:0])
                    root = trial;
            end
            return root[23:0];
        endfunction

        function void note_sample(smp_t item);
            logic [23:0] mag;
            logic [63:0] sq;
            logic [23:0] g;
            res_t        r;
            mag = item.sample[23] ? ~item.sample + 24'd1 : item.sample;
            sq  = {40'd0, mag} * {40'd0, mag};
            if (energy > (64'hFFFF_FFFF_FFFF_FFFF - sq))
            begin
                energy         = 64'hFFFF_FFFF_FFFF_FFFF;
                energy_clipped = 1'b1;
            end
            else
                energy = energy + sq;
            if (!item.end_of_buffer)
                return;
            g = inv_sqrt_gain(energy);
            if (g < lowest_gain)
                lowest_gain = g;
            r.buffer_gain      = g;
            r.auto_gain        = lowest_gain;
            r.set_done         = item.end_of_set;
            r.energy_saturated = energy_clipped;
            pending_gains.push_back(r);
            energy         = '0;
            energy_clipped = 1'b0;
            if (item.end_of_set)
                lowest_gain = GAIN_ONE;
        endfunction

        function void compare_field(string name, logic [23:0] want, logic [23:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_gains.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual gain %0d auto %0d",
                         $time, got.buffer_gain, got.auto_gain);
                errors++;
                return;
            end
            want = pending_gains.pop_front();
            compare_field("buffer_gain", want.buffer_gain, got.buffer_gain);
            compare_field("auto_gain", want.auto_gain, got.auto_gain);
            compare_field("set_done", 24'(want.set_done), 24'(got.set_done));
            compare_field("energy_saturated", 24'(want.energy_saturated),
                          24'(got.energy_saturated));
        endfunction
    endclass

    logic clk;
    logic rst_n     = 1'b0;
    logic smp_valid = 1'b0;
    logic smp_stall;
    smp_t smp       = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    gain_tracker tracker = new();
    bit          quiet   = 1'b0;
    int          samples_sent = 0;

    impulse_energy_auto_gain_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp       (smp),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic send_sample(input smp_t item);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            smp_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_valid <= 1'b1;
        smp       <= item;
        do @(posedge clk); while (smp_stall !== 1'b0);
        tracker.note_sample(item);
        samples_sent++;
    endtask

    task automatic send_one(input logic signed [23:0] value, input bit eob, input bit eos);
        smp_t item;
        item.sample        = value;
        item.end_of_buffer = eob;
        item.end_of_set    = eos;
        send_sample(item);
    endtask

    function automatic logic signed [23:0] pick_sample(flavour_t flavour);
        logic signed [23:0] v;
        case (flavour)
            EXTREMES:
            begin
                case ($urandom_range(0, 4))
                    0: v = SAMPLE_MIN;
                    1: v = SAMPLE_MAX;
                    2: v = '0;
                    3: v = 24'sd1;
                    default: v = -24'sd1;
                endcase
            end
            QUIET_LEVEL: v = 24'($signed($urandom_range(0, 8191)) - 4096);
            LOUD:
            begin
                v = 24'($urandom_range(4194304, 8388607));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: v = 24'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_buffer(input int len, input flavour_t flavour, input bit closes_set);
        bit last;
        for (int i = 0; i < len; i++)
        begin
            last = (i == len - 1);
            // stray end_of_set inside the buffer now and then
            send_one(pick_sample(flavour), last,
                     last ? closes_set : ($urandom_range(0, 9) == 0));
        end
    endtask

    // result side: random hold-off before each request is taken
    initial
    begin
        int hold;
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 7);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                res_stall <= 1'b0;
            end
            do @(posedge clk); while (res_valid !== 1'b1);
            tracker.check_result(res);
        end
    end

    initial
    begin
        int          len;
        int          buffers;
        flavour_t    flavour;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero energy, exactly 1.0, just under and just over 1.0, then near 2.0
        send_one('0, 1'b1, 1'b0);
        send_one(SAMPLE_MIN, 1'b1, 1'b0);
        send_one(SAMPLE_MAX, 1'b0, 1'b1);
        send_one(24'sd1, 1'b1, 1'b0);
        send_one(SAMPLE_MIN, 1'b0, 1'b0);
        send_one(24'sd1, 1'b1, 1'b0);
        send_one(SAMPLE_MAX, 1'b0, 1'b0);
        send_one(-SAMPLE_MAX, 1'b1, 1'b1);
        send_one('0, 1'b1, 1'b1);
        send_one(24'sh555555, 1'b0, 1'b0);
        send_one(24'shAAAAAA, 1'b0, 1'b0);
        send_one(-24'sd1, 1'b1, 1'b1);

        samples_sent = 0;
        while (samples_sent < RANDOM_SAMPLES)
        begin
            quiet   = ($urandom_range(0, 5) == 0);
            buffers = $urandom_range(1, 4);
            for (int b = 0; b < buffers; b++)
            begin
                case ($urandom_range(0, 19))
                    0:       len = 1;
                    1, 2:    len = $urandom_range(13, 64);
                    default: len = $urandom_range(1, 12);
                endcase
                flavour = flavour_t'($urandom_range(0, 3));
                send_buffer(len, flavour, b == buffers - 1);
            end
        end
        quiet = 1'b0;
        smp_valid <= 1'b0;

        while (tracker.pending_gains.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_gains.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
